### hw/rtl/cbd_pkg.sv
// Package for the chunked body decoder: widths, codes, item and result types.
// Used by the channel interfaces and every module of the decoder.
`timescale 1ns / 1ps

package cbd_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_OUT_W       = 32;
  localparam int unsigned CFG_W           = 32;
  localparam int unsigned SIZE_BITS_DEF   = 32;
  localparam int unsigned LENGTH_BITS_DEF = 32;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;

  typedef enum logic [3:0] {
    PH_SIZE,
    PH_EXT,
    PH_DATA,
    PH_END,
    PH_END_CR,
    PH_TRAILER,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic {
    ERR_MALFORMED = 1'b0,
    ERR_TOO_LARGE = 1'b1
  } err_e;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic              new_message;
  } item_t;

  typedef struct packed {
    kind_e                kind;
    logic [BYTE_W-1:0]    payload_byte;
    err_e                 error_kind;
    logic [LEN_OUT_W-1:0] body_length;
  } result_t;

  // {valid, value} of an ASCII hex digit
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### hw/rtl/cbd_in_if.sv
// Input channel of the chunked body decoder: valid/ready plus one body byte.
// Depends on cbd_pkg for the byte width.
`timescale 1ns / 1ps

interface cbd_in_if;
  import cbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] body_byte;
  logic              new_message;

  modport source (output valid, body_byte, new_message, input ready);
  modport sink   (input valid, body_byte, new_message, output ready);
endinterface

### hw/rtl/cbd_out_if.sv
// Result channel of the chunked body decoder: valid/ready plus one result.
// Depends on cbd_pkg for field widths.
`timescale 1ns / 1ps

interface cbd_out_if;
  import cbd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [BYTE_W-1:0]    payload_byte;
  logic                 error_kind;
  logic [LEN_OUT_W-1:0] body_length;

  modport source (output valid, kind, payload_byte, error_kind, body_length, input ready);
  modport sink   (input valid, kind, payload_byte, error_kind, body_length, output ready);
endinterface

### hw/rtl/cbd_in_stage.sv
// Input register of the chunked body decoder: holds one accepted byte.
// Depends on cbd_pkg and cbd_in_if.
`timescale 1ns / 1ps

module cbd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  cbd_in_if.sink          body_i,
  input  logic            advance_i,
  output logic            valid_o,
  output cbd_pkg::item_t  item_o
);
  import cbd_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign body_i.ready = !valid_q || advance_i;
  assign valid_o      = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (body_i.ready) begin
      valid_q <= body_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (body_i.valid && body_i.ready) begin
      item_q <= '{body_byte: body_i.body_byte, new_message: body_i.new_message};
    end
  end

endmodule

### hw/rtl/cbd_decode.sv
// Framing state and single-pass decode of one body byte for the chunked decoder.
// Holds the size limit register. Depends on cbd_pkg.
`timescale 1ns / 1ps

module cbd_decode #(
  parameter int unsigned SIZE_BITS   = cbd_pkg::SIZE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = cbd_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cbd_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         step_i,
  input  cbd_pkg::item_t               item_i,
  output logic                         emit_o,
  output cbd_pkg::result_t             result_o
);
  import cbd_pkg::*;

  localparam int unsigned LW = (LENGTH_BITS > LEN_OUT_W) ? LENGTH_BITS : LEN_OUT_W;

  logic [CFG_W-1:0]       max_q;
  phase_e                 phase_q, phase_d, phase_c;
  logic [SIZE_BITS-1:0]   size_q, size_d, size_c;
  logic [SIZE_BITS-1:0]   left_q, left_d, left_c;
  logic [LENGTH_BITS-1:0] total_q, total_d, total_c;
  logic                   digit_q, digit_d, digit_c;
  logic                   space_q, space_d, space_c;
  logic                   pcr_q, pcr_d, pcr_c;
  logic                   nonempty_q, nonempty_d, nonempty_c;

  logic [BYTE_W-1:0] c;
  logic [4:0]        hex;
  logic [LW-1:0]     total_ext, total_out_ext;
  logic              over_limit;
  logic              fail, fail_large;

  assign c   = item_i.body_byte;
  assign hex = hex_digit(c);

  // a new message starts from the reset state, the limit stays
  always_comb begin
    if (item_i.new_message) begin
      phase_c    = PH_SIZE;
      size_c     = '0;
      left_c     = '0;
      total_c    = '0;
      digit_c    = 1'b0;
      space_c    = 1'b0;
      pcr_c      = 1'b0;
      nonempty_c = 1'b0;
    end else begin
      phase_c    = phase_q;
      size_c     = size_q;
      left_c     = left_q;
      total_c    = total_q;
      digit_c    = digit_q;
      space_c    = space_q;
      pcr_c      = pcr_q;
      nonempty_c = nonempty_q;
    end
  end

  assign total_ext  = LW'(total_c);
  assign over_limit = (max_q != '0) && (total_ext > LW'(max_q));

  always_comb begin
    phase_d    = phase_c;
    size_d     = size_c;
    left_d     = left_c;
    total_d    = total_c;
    digit_d    = digit_c;
    space_d    = space_c;
    pcr_d      = pcr_c;
    nonempty_d = nonempty_c;
    emit_o     = 1'b0;
    fail       = 1'b0;
    fail_large = 1'b0;
    result_o.kind         = KIND_PAYLOAD;
    result_o.payload_byte = '0;
    result_o.error_kind   = ERR_MALFORMED;

    case (phase_c)
      PH_SIZE, PH_EXT: begin
        if (c == CH_LF) begin
          if (!digit_c) begin
            fail = 1'b1;
          end else if (size_c == '0) begin
            phase_d    = PH_TRAILER;
            pcr_d      = 1'b0;
            nonempty_d = 1'b0;
          end else begin
            left_d  = size_c;
            phase_d = PH_DATA;
          end
        end else if (phase_c == PH_SIZE) begin
          if (c inside {CH_SPACE, CH_TAB, CH_CR}) begin
            if (digit_c) space_d = 1'b1;
          end else if (c == CH_SEMI) begin
            if (!digit_c || space_c) fail = 1'b1;
            else phase_d = PH_EXT;
          end else if (!hex[4] || space_c || (size_c[SIZE_BITS-1 -: 4] != 4'd0)) begin
            fail = 1'b1;
          end else begin
            size_d  = {size_c[SIZE_BITS-5:0], hex[3:0]};
            digit_d = 1'b1;
          end
        end
      end
      PH_DATA: begin
        if (total_c != '1) total_d = total_c + 1'b1;
        left_d = left_c - 1'b1;
        if (left_c == SIZE_BITS'(1)) phase_d = PH_END;
        emit_o                = 1'b1;
        result_o.payload_byte = c;
      end
      PH_END, PH_END_CR: begin
        if (c == CH_LF) begin
          if (over_limit) begin
            fail       = 1'b1;
            fail_large = 1'b1;
          end else begin
            phase_d = PH_SIZE;
            size_d  = '0;
            digit_d = 1'b0;
            space_d = 1'b0;
          end
        end else if (c == CH_CR && phase_c == PH_END) begin
          phase_d = PH_END_CR;
        end else begin
          fail = 1'b1;
        end
      end
      PH_TRAILER: begin
        if (c == CH_LF) begin
          if (!nonempty_c) begin
            phase_d       = PH_DONE;
            emit_o        = 1'b1;
            result_o.kind = KIND_DONE;
          end
          pcr_d      = 1'b0;
          nonempty_d = 1'b0;
        end else if (c == CH_CR) begin
          if (pcr_c) nonempty_d = 1'b1;
          pcr_d = 1'b1;
        end else begin
          nonempty_d = 1'b1;
          pcr_d      = 1'b0;
        end
      end
      default: begin
        // done or error: drop bytes until the next message
      end
    endcase

    if (fail) begin
      phase_d             = PH_ERROR;
      emit_o              = 1'b1;
      result_o.kind       = KIND_ERROR;
      result_o.error_kind = fail_large ? ERR_TOO_LARGE : ERR_MALFORMED;
    end

    // saturate the reported length to the output width
    total_out_ext        = LW'(total_d);
    result_o.body_length = (total_out_ext > LW'({LEN_OUT_W{1'b1}})) ?
                           '1 : total_out_ext[LEN_OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q      <= '0;
      phase_q    <= PH_SIZE;
      size_q     <= '0;
      left_q     <= '0;
      total_q    <= '0;
      digit_q    <= 1'b0;
      space_q    <= 1'b0;
      pcr_q      <= 1'b0;
      nonempty_q <= 1'b0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (step_i) begin
        phase_q    <= phase_d;
        size_q     <= size_d;
        left_q     <= left_d;
        total_q    <= total_d;
        digit_q    <= digit_d;
        space_q    <= space_d;
        pcr_q      <= pcr_d;
        nonempty_q <= nonempty_d;
      end
    end
  end

endmodule

### hw/rtl/cbd_out_stage.sv
// Result register of the chunked body decoder: holds one result until taken.
// Depends on cbd_pkg and cbd_out_if.
`timescale 1ns / 1ps

module cbd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  cbd_pkg::result_t  result_i,
  output logic              free_o,
  cbd_out_if.source         result_o
);
  import cbd_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign free_o = !valid_q || result_o.ready;

  assign result_o.valid        = valid_q;
  assign result_o.kind         = data_q.kind;
  assign result_o.payload_byte = data_q.payload_byte;
  assign result_o.error_kind   = data_q.error_kind;
  assign result_o.body_length  = data_q.body_length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      data_q <= result_i;
    end
  end

endmodule

### hw/rtl/chunked_body_decoder.sv
// Top level of the chunked transfer-coding body decoder.
// Depends on cbd_pkg, cbd_in_if, cbd_out_if, cbd_in_stage, cbd_decode, cbd_out_stage.
//
// Usage:
//  - body_i carries one raw body byte per transaction; new_message set on a
//    byte restarts decoding from a clean state with that byte.
//  - result_o carries at most one result per byte: a payload byte, body
//    complete with the total length, or an error (malformed or too large).
//  - cfg_we_i/cfg_wdata_i write the body size limit (zero: no limit); write
//    it only while no byte is in flight.
//  - Path: an accepted byte goes into the input register, then through the
//    decode logic into the result register.
//  - Throughput: one byte per cycle while the byte has no result or the result
//    register is free; the decode step that updates the framing state is combinational.
//  - Reset clears the framing state and the limit; the decoder starts at a
//    size line. Nothing needs clearing afterwards.
//  - When the receiver stalls, the result register holds; a byte that has no
//    result still passes, and a byte that has one waits in the input
//    register, which then drops ready.
`timescale 1ns / 1ps

module chunked_body_decoder #(
  parameter int unsigned SIZE_BITS   = cbd_pkg::SIZE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = cbd_pkg::LENGTH_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cbd_pkg::CFG_W-1:0] cfg_wdata_i,
  cbd_in_if.sink                    body_i,
  cbd_out_if.source                 result_o
);
  import cbd_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    emit;
  result_t result;
  logic    out_free;
  logic    advance;

  // a byte without a result never waits on the receiver
  assign advance = s1_valid && (!emit || out_free);

  cbd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .body_i    (body_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  cbd_decode #(
    .SIZE_BITS   (SIZE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .item_i      (s1_item),
    .emit_o      (emit),
    .result_o    (result)
  );

  cbd_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit),
    .result_i (result),
    .free_o   (out_free),
    .result_o (result_o)
  );

endmodule

### tb/tb_top.sv
// Self-checking bench for chunked_body_decoder: directed framing cases, limit
// changes and random chunked bodies with stalls on both channels.
// Depends on cbd_pkg, cbd_in_if, cbd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import cbd_pkg::*;

  localparam int          CLK_PERIOD   = 20;
  localparam int          RESET_CYCLES = 7;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          RANDOM_ITEMS = 560;
  localparam int          MAX_REPORTS  = 10;
  localparam longint      TIMEOUT_NS   = 40_000_000;
  localparam logic [31:0] NO_LIMIT     = 32'd0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  cbd_in_if  body_if ();
  cbd_out_if res_if ();

  chunked_body_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .body_i     (body_if),
    .result_o   (res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Decoder state as the bench predicts it
  phase_e      dec_phase;
  logic [31:0] size_acc;
  logic [31:0] chunk_left;
  logic [31:0] body_total;
  logic [31:0] size_limit;
  bit          digits_seen;
  bit          gap_after_digits;
  bit          trailer_cr;
  bit          trailer_text;

  result_t     expected_results[$];
  logic [7:0]  frame_bytes[$];

  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  int live_items, results_checked, bad_results, limit_writes;
  int payload_seen, bodies_done, malformed_seen, oversize_seen;

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    return -1;
  endfunction

  function automatic void expect_result(kind_e k, logic [7:0] b, err_e e);
    result_t r;
    r.kind         = k;
    r.payload_byte = b;
    r.error_kind   = e;
    r.body_length  = body_total;
    expected_results.push_back(r);
    case (k)
      KIND_PAYLOAD: payload_seen++;
      KIND_DONE:    bodies_done++;
      default: begin
        if (e == ERR_TOO_LARGE) oversize_seen++;
        else malformed_seen++;
      end
    endcase
  endfunction

  function automatic void start_size_line();
    dec_phase        = PH_SIZE;
    size_acc         = '0;
    digits_seen      = 1'b0;
    gap_after_digits = 1'b0;
  endfunction

  function automatic void decoder_clear();
    start_size_line();
    chunk_left   = '0;
    body_total   = '0;
    trailer_cr   = 1'b0;
    trailer_text = 1'b0;
  endfunction

  function automatic void raise_error(err_e e);
    dec_phase = PH_ERROR;
    expect_result(KIND_ERROR, 8'h00, e);
  endfunction

  function automatic void size_line_done();
    if (!digits_seen) begin
      raise_error(ERR_MALFORMED);
    end else if (size_acc == 0) begin
      dec_phase    = PH_TRAILER;
      trailer_cr   = 1'b0;
      trailer_text = 1'b0;
    end else begin
      chunk_left = size_acc;
      dec_phase  = PH_DATA;
    end
  endfunction

  // Limit is checked only once the chunk terminator is complete
  function automatic void chunk_done();
    if (size_limit != NO_LIMIT && body_total > size_limit) raise_error(ERR_TOO_LARGE);
    else start_size_line();
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic restart);
    int d;
    if (restart) decoder_clear();
    if (dec_phase != PH_DONE && dec_phase != PH_ERROR) live_items++;
    d = hex_val(c);
    case (dec_phase)
      PH_SIZE: begin
        if (c == CH_LF) begin
          size_line_done();
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
          if (digits_seen) gap_after_digits = 1'b1;
        end else if (c == CH_SEMI) begin
          if (!digits_seen || gap_after_digits) raise_error(ERR_MALFORMED);
          else dec_phase = PH_EXT;
        end else if (d < 0 || gap_after_digits || size_acc[31:28] != 4'h0) begin
          raise_error(ERR_MALFORMED);
        end else begin
          size_acc    = {size_acc[27:0], 4'(d)};
          digits_seen = 1'b1;
        end
      end
      PH_EXT: begin
        if (c == CH_LF) size_line_done();
      end
      PH_DATA: begin
        if (body_total != '1) body_total++;
        chunk_left--;
        if (chunk_left == 0) dec_phase = PH_END;
        expect_result(KIND_PAYLOAD, c, ERR_MALFORMED);
      end
      PH_END: begin
        if (c == CH_CR) dec_phase = PH_END_CR;
        else if (c == CH_LF) chunk_done();
        else raise_error(ERR_MALFORMED);
      end
      PH_END_CR: begin
        if (c == CH_LF) chunk_done();
        else raise_error(ERR_MALFORMED);
      end
      PH_TRAILER: begin
        if (c == CH_LF) begin
          if (!trailer_text) begin
            dec_phase = PH_DONE;
            expect_result(KIND_DONE, 8'h00, ERR_MALFORMED);
          end else begin
            trailer_cr   = 1'b0;
            trailer_text = 1'b0;
          end
        end else if (c == CH_CR) begin
          // a second CR makes the line non-empty
          if (trailer_cr) trailer_text = 1'b1;
          trailer_cr = 1'b1;
        end else begin
          trailer_text = 1'b1;
          trailer_cr   = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(input string msg);
    bad_results++;
    if (bad_results <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Compare every result transaction and drive a random stall pattern on ready
  always @(posedge clk) begin : result_sink
    int      stall;
    int      rx_hold;
    result_t exp_r;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d byte=%02h err=%0d len=%0d",
                                  res_if.kind, res_if.payload_byte, res_if.error_kind,
                                  res_if.body_length));
      end else begin
        exp_r = expected_results.pop_front();
        results_checked++;
        if (res_if.kind !== exp_r.kind || res_if.payload_byte !== exp_r.payload_byte ||
            res_if.error_kind !== exp_r.error_kind ||
            res_if.body_length !== exp_r.body_length) begin
          report_mismatch($sformatf(
            "expected kind=%0d byte=%02h err=%0d len=%0d, got kind=%0d byte=%02h err=%0d len=%0d",
            exp_r.kind, exp_r.payload_byte, exp_r.error_kind, exp_r.body_length,
            res_if.kind, res_if.payload_byte, res_if.error_kind, res_if.body_length));
        end
      end
    end
    if (rx_hold > 0) begin
      rx_hold--;
    end else if (res_if.ready === 1'b1) begin
      stall = rx_stalls ? idle_gap() : 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        rx_hold = stall - 1;
      end else begin
        rx_hold = $urandom_range(0, 5);
      end
    end else begin
      res_if.ready <= 1'b1;
      rx_hold = $urandom_range(0, 5);
    end
  end

  // Valid stays high after a transaction so back-to-back bytes never toggle it
  task automatic send_byte(input logic [7:0] value, input logic restart);
    int gap;
    gap = tx_gaps ? idle_gap() : 0;
    if (gap > 0) begin
      body_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    body_if.valid       <= 1'b1;
    body_if.body_byte   <= value;
    body_if.new_message <= restart;
    @(posedge clk);
    while (body_if.ready !== 1'b1) @(posedge clk);
    decode_byte(value, restart);
  endtask

  task automatic send_text(input string s, input logic restart);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], restart && i == 0);
  endtask

  task automatic wait_drain();
    body_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk);
    cfg_we_i   <= 1'b0;
    size_limit = value;
    limit_writes++;
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  function automatic void add_line_end();
    if ($urandom_range(0, 1)) frame_bytes.push_back(CH_CR);
    frame_bytes.push_back(CH_LF);
  endfunction

  function automatic void add_blanks();
    repeat ($urandom_range(0, 2)) frame_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void add_size_line(input int unsigned sz);
    string digits;
    digits = $sformatf("%0h", sz);
    for (int i = 0; i < digits.len(); i++) begin
      if (digits[i] >= 8'h61 && $urandom_range(0, 1)) digits[i] = digits[i] - 8'h20;
    end
    if ($urandom_range(0, 5) == 0) add_blanks();
    if ($urandom_range(0, 7) == 0) add_text("00");
    add_text(digits);
    // a ';' after trailing blanks would be malformed, so pick one or the other
    if ($urandom_range(0, 5) == 0) add_text(";ext=v");
    else if ($urandom_range(0, 5) == 0) add_blanks();
    add_line_end();
  endfunction

  function automatic void build_random_body();
    int unsigned sz;
    frame_bytes.delete();
    repeat ($urandom_range(0, 4)) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 96) : $urandom_range(1, 12);
      add_size_line(sz);
      repeat (sz) frame_bytes.push_back(8'($urandom_range(0, 255)));
      add_line_end();
    end
    add_size_line(0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
      add_line_end();
    end
    add_line_end();
  endfunction

  function automatic void corrupt_frame();
    int         pos;
    logic [7:0] junk;
    pos  = $urandom_range(0, frame_bytes.size() - 1);
    junk = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0:       frame_bytes[pos] = junk;
      1:       frame_bytes.delete(pos);
      default: frame_bytes.insert(pos, junk);
    endcase
  endfunction

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == 0 || $urandom_range(0, 99) == 0);
    end
  endtask

  task automatic test_basic_framing();
    send_text("1\015\nZ\015\n0\015\n\015\n", 1'b1);
    // bytes after completion are dropped
    send_text("xyz", 1'b0);
    send_text("2\n", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\n0\n\n", 1'b0);
    // payload that looks like framing, trimmed size, extensions
    send_text(" \tA \t\015\n\015\n0\015\n\015\n;;x\015\n", 1'b1);
    send_text("3;ext=\"v\"\015\nabc\n0;last\n\n", 1'b0);
    // restart in the middle of a chunk
    send_text("5\nab", 1'b1);
    send_text("1\nc\n0\n\n", 1'b1);
  endtask

  task automatic test_size_line_errors();
    send_text("\015\n", 1'b1);
    send_text(" \t\n", 1'b1);
    send_text("g", 1'b1);
    send_text("1 2", 1'b1);
    send_text(";1", 1'b1);
    send_text("1 ;", 1'b1);
    // anything after an error is dropped
    send_text("q1\n0\n\n", 1'b1);
    send_text("1\nA\n\n", 1'b1);
  endtask

  task automatic test_size_extremes();
    send_text("100000000", 1'b1);
    send_text("0000000FFFFFFFF\nabc", 1'b1);
    send_text("fFfFfFfF\015\nxy", 1'b1);
    send_text("1\nq\n0\n\n", 1'b1);
  endtask

  task automatic test_chunk_terminator();
    send_text("1\nAB", 1'b1);
    send_text("1\nA\015B", 1'b1);
    send_text("1\nA\015\015", 1'b1);
    send_text("1\nA\n\015\n", 1'b1);
  endtask

  task automatic test_trailers();
    send_text("0\nX-A: 1\015\nY\n\015\n", 1'b1);
    send_text("0\n\015\015\n\n", 1'b1);
    send_text("0\n\015x\n\015\n", 1'b1);
    send_text("0;e\n\n", 1'b1);
  endtask

  task automatic test_body_limit();
    write_limit(32'd5);
    send_text("5\n12345\n0\n\n", 1'b1);
    send_text("3\nabc\n3\ndef\n", 1'b1);
    send_text("6\n123456\015\n", 1'b1);
    write_limit(32'd1);
    send_text("1\nx\n1\ny\015\n", 1'b1);
    write_limit(32'hFFFF_FFFF);
    send_text("2\nab\n0\n\n", 1'b1);
    write_limit(NO_LIMIT);
    send_text("4\nwxyz\n0\n\n", 1'b1);
  endtask

  task automatic test_random_traffic();
    int         start, next_cfg;
    bit         paused;
    logic [31:0] lim;
    start    = live_items;
    next_cfg = 0;
    paused   = 1'b0;
    while (live_items - start < RANDOM_ITEMS) begin
      if (live_items - start >= next_cfg) begin
        case ($urandom_range(0, 4))
          0:       lim = NO_LIMIT;
          1:       lim = 32'd1;
          2:       lim = 32'hFFFF_FFFF;
          3:       lim = $urandom_range(20, 120);
          default: lim = $urandom();
        endcase
        write_limit(lim);
        tx_gaps   = $urandom_range(0, 3) != 0;
        rx_stalls = $urandom_range(0, 3) != 0;
        next_cfg += $urandom_range(100, 200);
      end
      // hold the sender once until every result is back
      if (!paused && live_items - start >= RANDOM_ITEMS / 2) begin
        wait_drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_random_body();
        if ($urandom_range(0, 3) == 0) corrupt_frame();
      end
      send_frame();
    end
  endtask

  initial begin : main
    body_if.valid       <= 1'b0;
    body_if.body_byte   <= '0;
    body_if.new_message <= 1'b0;
    decoder_clear();
    size_limit = NO_LIMIT;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_framing();
    test_size_line_errors();
    test_size_extremes();
    test_chunk_terminator();
    test_trailers();
    test_body_limit();
    test_random_traffic();

    wait_drain();
    $display("Decoded %0d live bytes: %0d payload, %0d completed bodies,",
             live_items, payload_seen, bodies_done);
    $display("%0d malformed, %0d oversize; limit written %0d times; %0d results checked",
             malformed_seen, oversize_seen, limit_writes, results_checked);
    if (bad_results == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
